// ===== hdl/tfb_pkg.sv =====
// Shared types, constants and the CRC-8 step function of the telemetry frame builder.
package tfb_pkg;

    // Register reset values and default store depth
    localparam logic [7:0] BATCH_VER_RST   = 8'd4;
    localparam logic [7:0] LIVE_VER_RST    = 8'd17;
    localparam int         MAX_SAMPLES_DEF = 16;

    // Reflected Dallas/Maxim polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Header and live frames both carry ten bytes ahead of their CRC
    localparam logic [3:0] LAST_STEP = 4'd9;

    // Configuration port: two byte-wide registers at word addresses
    localparam int   APB_AW        = 3;
    localparam logic REG_BATCH_VER = 1'b0;
    localparam logic REG_LIVE_VER  = 1'b1;

    typedef enum logic [1:0] {
        OP_HDR    = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_LIVE   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Input item as carried on the slave tdata bus, lowest field last
    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] pulse_rate;
        logic [7:0]  vane_off;
        logic [7:0]  vane_on;
        logic [15:0] speed_word;
        logic [7:0]  vane_byte;
        logic [7:0]  signal_quality;
        logic [15:0] panel_mv;
        logic [15:0] battery_mv;
        logic [4:0]  sample_count;
        logic [15:0] cycle_number;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    // Source of the byte placed into the output register
    typedef enum logic [4:0] {
        BS_BVER,
        BS_LVER,
        BS_CYC_LO,
        BS_CYC_HI,
        BS_CNT_LO,
        BS_ZERO,
        BS_BAT_LO,
        BS_BAT_HI,
        BS_SOL_LO,
        BS_SOL_HI,
        BS_SIG,
        BS_VANE,
        BS_VON,
        BS_VOFF,
        BS_RATE_LO,
        BS_RATE_HI,
        BS_SPD_LO,
        BS_SPD_HI,
        BS_BCRC,
        BS_LCRC
    } t_bsel;

    typedef enum logic [2:0] {
        CRC_NONE,
        CRC_BATCH_INIT,
        CRC_BATCH,
        CRC_LIVE_INIT,
        CRC_LIVE
    } t_crc_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_HDR,
        S_VANE,
        S_SPD,
        S_BCRC,
        S_LIVE,
        S_LCRC
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    emit;
        t_bsel   bsel;
        logic    is_crc;
        logic    last;
        t_crc_op crc_op;
        logic    hdr_commit;
        logic    store;
        logic    dump_adv;
        logic    close;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_op  op;
        logic out_free;
        logic sample_ok;
        logic closing;
        logic count_zero;
        logic dump_last;
    } t_sts;

    // One byte through the reflected CRC-8
    function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// ===== hdl/tfb_ctrl.sv =====
// Frame sequencer: walks header, sample, speed dump and live frames one byte at a time.
module tfb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  tfb_pkg::t_sts i_sts,
    output tfb_pkg::t_cmd o_cmd
);
    import tfb_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_step, n_step;
    logic       r_hi, n_hi;

    function automatic t_bsel hdr_sel(input logic [3:0] s);
        t_bsel b;
        case (s)
            4'd0:    b = BS_BVER;
            4'd1:    b = BS_CYC_LO;
            4'd2:    b = BS_CYC_HI;
            4'd3:    b = BS_CNT_LO;
            4'd4:    b = BS_ZERO;
            4'd5:    b = BS_BAT_LO;
            4'd6:    b = BS_BAT_HI;
            4'd7:    b = BS_SOL_LO;
            4'd8:    b = BS_SOL_HI;
            default: b = BS_SIG;
        endcase
        return b;
    endfunction

    function automatic t_bsel live_sel(input logic [3:0] s);
        t_bsel b;
        case (s)
            4'd0:    b = BS_LVER;
            4'd1:    b = BS_VON;
            4'd2:    b = BS_VOFF;
            4'd3:    b = BS_RATE_LO;
            4'd4:    b = BS_RATE_HI;
            4'd5:    b = BS_BAT_LO;
            4'd6:    b = BS_BAT_HI;
            4'd7:    b = BS_SOL_LO;
            4'd8:    b = BS_SOL_HI;
            default: b = BS_SIG;
        endcase
        return b;
    endfunction

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_hi    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_hi    <= n_hi;
        end
    end

    // Next state and commands; every byte waits for a free output register
    always_comb begin
        n_state           = r_state;
        n_step            = r_step;
        n_hi              = r_hi;
        o_cmd.load        = 1'b0;
        o_cmd.emit        = 1'b0;
        o_cmd.bsel        = BS_ZERO;
        o_cmd.is_crc      = 1'b0;
        o_cmd.last        = 1'b0;
        o_cmd.crc_op      = CRC_NONE;
        o_cmd.hdr_commit  = 1'b0;
        o_cmd.store       = 1'b0;
        o_cmd.dump_adv    = 1'b0;
        o_cmd.close       = 1'b0;
        o_s_tready        = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_step = '0;
                n_hi   = 1'b0;
                case (i_sts.op)
                    OP_HDR:    n_state = S_HDR;
                    OP_SAMPLE: n_state = i_sts.sample_ok ? S_VANE : S_IDLE;
                    OP_LIVE:   n_state = S_LIVE;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_HDR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.bsel       = hdr_sel(r_step);
                    o_cmd.crc_op     = (r_step == '0) ? CRC_BATCH_INIT : CRC_BATCH;
                    o_cmd.hdr_commit = (r_step == '0);
                    if (r_step == LAST_STEP) begin
                        o_cmd.last = !i_sts.count_zero;
                        n_state    = i_sts.count_zero ? S_BCRC : S_IDLE;
                    end else begin
                        n_step = r_step + 4'd1;
                    end
                end
            end
            S_VANE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.bsel   = BS_VANE;
                    o_cmd.crc_op = CRC_BATCH;
                    o_cmd.store  = 1'b1;
                    o_cmd.last   = !i_sts.closing;
                    n_state      = i_sts.closing ? S_SPD : S_IDLE;
                end
            end
            S_SPD: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.bsel     = r_hi ? BS_SPD_HI : BS_SPD_LO;
                    o_cmd.crc_op   = CRC_BATCH;
                    o_cmd.dump_adv = r_hi;
                    n_hi           = !r_hi;
                    if (r_hi && i_sts.dump_last) begin
                        n_state = S_BCRC;
                    end
                end
            end
            S_BCRC: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.bsel   = BS_BCRC;
                    o_cmd.is_crc = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.close  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_LIVE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.bsel   = live_sel(r_step);
                    o_cmd.crc_op = (r_step == '0) ? CRC_LIVE_INIT : CRC_LIVE;
                    if (r_step == LAST_STEP) begin
                        n_state = S_LCRC;
                    end else begin
                        n_step = r_step + 4'd1;
                    end
                end
            end
            S_LCRC: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.bsel   = BS_LCRC;
                    o_cmd.is_crc = 1'b1;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/tfb_dp.sv =====
// Datapath: item capture, batch progress, speed store, two CRC accumulators, output register.
module tfb_dp #(
    parameter int MAX_SAMPLES = tfb_pkg::MAX_SAMPLES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tfb_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    // captured item
    input  tfb_pkg::t_item             i_item,
    input  tfb_pkg::t_op               i_op,
    // controller link
    input  tfb_pkg::t_cmd              i_cmd,
    output tfb_pkg::t_sts              o_sts,
    // result channel
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [7:0]                 o_m_tdata,
    output logic                       o_m_tuser,
    output logic                       o_m_tlast
);
    import tfb_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    logic [7:0]       r_bver;
    logic [7:0]       r_lver;
    t_item            r_item;
    t_op              r_op;
    logic [7:0]       r_crc;
    logic [7:0]       r_lcrc;
    logic [CNT_W-1:0] r_expected;
    logic [CNT_W-1:0] r_received;
    logic             r_open;
    logic [IDX_W-1:0] r_rd_idx;
    logic [15:0]      r_spd [MAX_SAMPLES];
    logic [15:0]      r_rd_word;
    logic             r_m_valid;
    logic [7:0]       r_m_data;
    logic             r_m_user;
    logic             r_m_last;

    logic [CNT_W-1:0] sat_count;
    logic [IDX_W-1:0] n_rd_idx;
    logic [7:0]       byte_sel;
    logic [7:0]       crc_base;
    logic [7:0]       n_crc_val;
    logic             out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bver <= BATCH_VER_RST;
            r_lver <= LIVE_VER_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_LIVE_VER) begin
                r_lver <= pwdata[7:0];
            end else begin
                r_bver <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_BATCH_VER) ? {24'h0, r_bver} : {24'h0, r_lver};

    // Item capture at the input transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
            r_op   <= i_op;
        end
    end

    // Count saturates at the store depth
    assign sat_count = (r_item.sample_count > 5'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                                : CNT_W'(r_item.sample_count);

    // Byte select
    always_comb begin
        case (i_cmd.bsel)
            BS_BVER:    byte_sel = r_bver;
            BS_LVER:    byte_sel = r_lver;
            BS_CYC_LO:  byte_sel = r_item.cycle_number[7:0];
            BS_CYC_HI:  byte_sel = r_item.cycle_number[15:8];
            BS_CNT_LO:  byte_sel = 8'(sat_count);
            BS_BAT_LO:  byte_sel = r_item.battery_mv[7:0];
            BS_BAT_HI:  byte_sel = r_item.battery_mv[15:8];
            BS_SOL_LO:  byte_sel = r_item.panel_mv[7:0];
            BS_SOL_HI:  byte_sel = r_item.panel_mv[15:8];
            BS_SIG:     byte_sel = r_item.signal_quality;
            BS_VANE:    byte_sel = r_item.vane_byte;
            BS_VON:     byte_sel = r_item.vane_on;
            BS_VOFF:    byte_sel = r_item.vane_off;
            BS_RATE_LO: byte_sel = r_item.pulse_rate[7:0];
            BS_RATE_HI: byte_sel = r_item.pulse_rate[15:8];
            BS_SPD_LO:  byte_sel = r_rd_word[7:0];
            BS_SPD_HI:  byte_sel = r_rd_word[15:8];
            BS_BCRC:    byte_sel = r_crc;
            BS_LCRC:    byte_sel = r_lcrc;
            default:    byte_sel = 8'h00;
        endcase
    end

    // CRC step on the emitted byte
    always_comb begin
        case (i_cmd.crc_op)
            CRC_BATCH:      crc_base = r_crc;
            CRC_LIVE:       crc_base = r_lcrc;
            default:        crc_base = 8'h00;
        endcase
    end

    assign n_crc_val = crc8_byte(crc_base, byte_sel);

    // Dump read pointer: rewound by each stored sample, stepped after each high byte
    always_comb begin
        n_rd_idx = r_rd_idx;
        if (i_cmd.store) begin
            n_rd_idx = '0;
        end else if (i_cmd.dump_adv) begin
            n_rd_idx = r_rd_idx + IDX_W'(1);
        end
    end

    // Batch CRC and progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= '0;
            r_expected <= '0;
            r_received <= '0;
            r_open     <= 1'b0;
            r_rd_idx   <= '0;
        end else begin
            if (i_cmd.emit && (i_cmd.crc_op == CRC_BATCH_INIT || i_cmd.crc_op == CRC_BATCH)) begin
                r_crc <= n_crc_val;
            end
            if (i_cmd.hdr_commit) begin
                r_expected <= sat_count;
                r_received <= '0;
                r_open     <= (sat_count != '0);
            end
            if (i_cmd.store) begin
                r_received <= r_received + CNT_W'(1);
            end
            r_rd_idx <= n_rd_idx;
            if (i_cmd.close) begin
                r_open <= 1'b0;
            end
        end
    end

    // Live frame CRC, started fresh by each live record
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && (i_cmd.crc_op == CRC_LIVE_INIT || i_cmd.crc_op == CRC_LIVE)) begin
            r_lcrc <= n_crc_val;
        end
    end

    // Speed store, one entry per received sample; read word tracks the next pointer,
    // with the word being written passed straight through
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_spd[r_received[IDX_W-1:0]] <= r_item.speed_word;
        end
        if (i_cmd.store && (r_received[IDX_W-1:0] == n_rd_idx)) begin
            r_rd_word <= r_item.speed_word;
        end else begin
            r_rd_word <= r_spd[n_rd_idx];
        end
    end

    // Output register
    assign out_free = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_m_data <= byte_sel;
            r_m_user <= i_cmd.is_crc;
            r_m_last <= i_cmd.last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

    // Status toward the controller
    assign o_sts.op         = r_op;
    assign o_sts.out_free   = out_free;
    assign o_sts.sample_ok  = r_open && (r_received < r_expected);
    assign o_sts.closing    = ((r_received + CNT_W'(1)) == r_expected);
    assign o_sts.count_zero = (r_item.sample_count == 5'd0);
    assign o_sts.dump_last  = ((CNT_W'(r_rd_idx) + CNT_W'(1)) == r_received);

endmodule

// ===== hdl/telemetry_frame_builder_crc8_core.sv =====
// Top level of the telemetry frame builder with reflected CRC-8 closing.
//
// Slave stream carries one command item per transfer: tuser selects a batch
// header, a sample or a live record, tdata holds the field values. Master
// stream carries the frame bytes in transmit order, one per transfer; tuser
// flags the closing CRC byte and tlast marks the last byte caused by an item.
// The APB port holds the two version bytes (batch at 0x0, live at 0x4).
//
// An item is taken in its transfer and decoded, then emits one byte per cycle
// while the output register is free: 10 or 11 bytes for a header, 11 for a
// live record, 1 for a sample that does not close its batch, and up to 34
// for a closing sample (vane byte, two bytes per stored speed, CRC). The single
// byte-wide output register sets that rate. Ignored samples and unused op
// codes give no bytes.
//
// A new item is taken once the previous item's last byte sits in the output
// register. When the receiver stalls, the sequencer holds until the register
// frees up. Reset clears batch progress, closes any open batch, drops a
// pending output byte and restores the version registers.
module telemetry_frame_builder_crc8_core #(
    parameter int MAX_SAMPLES = tfb_pkg::MAX_SAMPLES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Slave stream
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // cycle_number[15:0], sample_count[20:16], battery_mv[36:21],
    // panel_mv[52:37], signal_quality[60:53], vane_byte[68:61],
    // speed_word[84:69], vane_on[92:85], vane_off[100:93],
    // pulse_rate[116:101], zero[119:117]
    input  logic [tfb_pkg::ITEM_W-1:0] i_s_tdata,
    // op[1:0]
    input  logic [1:0]                 i_s_tuser,
    // Master stream
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // out_byte[7:0]
    output logic [7:0]                 o_m_tdata,
    // is_crc[0]
    output logic                       o_m_tuser,
    output logic                       o_m_tlast,
    // APB configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tfb_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import tfb_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign pready = 1'b1;

    tfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tfb_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .i_item     (t_item'(i_s_tdata)),
        .i_op       (t_op'(i_s_tuser)),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== hdl/tfb_chk.sv =====
// Port-level checker for the telemetry frame builder, bound to the top level.
module tfb_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_valid,
    input logic       i_s_ready,
    input logic       i_m_valid,
    input logic       i_m_ready,
    input logic [7:0] i_m_data,
    input logic       i_m_user,
    input logic       i_m_last
);

    // A stalled result byte holds still
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_valid && !i_m_ready |=> i_m_valid && $stable(i_m_data) &&
                                    $stable(i_m_user) && $stable(i_m_last))
        else $error("result byte changed while stalled");

    // A CRC byte always closes the bytes of its item
    a_crc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_valid && i_m_user |-> i_m_last)
        else $error("CRC byte without tlast");

    // Only one item is in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_valid && i_s_ready |=> !i_s_ready)
        else $error("input ready right after a transfer");

    // Output register starts empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_valid)
        else $error("result valid right after reset");

endmodule

bind telemetry_frame_builder_crc8_core tfb_chk u_tfb_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_valid (i_s_tvalid),
    .i_s_ready (o_s_tready),
    .i_m_valid (o_m_tvalid),
    .i_m_ready (i_m_tready),
    .i_m_data  (o_m_tdata),
    .i_m_user  (o_m_tuser),
    .i_m_last  (o_m_tlast)
);

// ===== bench/telemetry_frame_builder_crc8_core_tb.sv =====
// Self-checking testbench for the telemetry frame builder: stream stimulus, byte-level prediction.
module telemetry_frame_builder_crc8_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tfb_pkg::*;

    localparam int SAMPLE_DEPTH = MAX_SAMPLES_DEF;
    localparam logic [APB_AW-1:0] ADDR_BATCH_VER = {REG_BATCH_VER, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_LIVE_VER  = {REG_LIVE_VER, 2'b00};
    // Cycles allowed for the block to settle after its last expected byte
    localparam int DRAIN_TAIL = 48;

    // One expected byte on the master stream
    typedef struct {
        logic [7:0] data;
        logic       is_crc;
        logic       last;
    } t_frame_byte;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    // cycle_number, sample_count, battery_mv, panel_mv, signal_quality, vane_byte,
    // speed_word, vane_on, vane_off, pulse_rate, zero pad (lowest bit up)
    logic [ITEM_W-1:0]   i_s_tdata;
    // op
    logic [1:0]          i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready;
    // out_byte
    logic [7:0]          o_m_tdata;
    // is_crc
    logic                o_m_tuser;
    logic                o_m_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // Frame builder shadow state
    logic [7:0]          batch_ver_reg;
    logic [7:0]          live_ver_reg;
    logic [7:0]          batch_crc;
    logic [7:0]          live_crc;
    logic [15:0]         speed_words [SAMPLE_DEPTH];
    int                  samples_due;
    int                  samples_seen;
    bit                  batch_is_open;

    t_frame_byte         expected_bytes [$];
    int                  bytes_predicted;
    int                  items_with_output;
    int                  error_count;
    bit                  steady_flow;

    telemetry_frame_builder_crc8_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // CRC-8, reflected, one data bit at a time, LSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ 8'h8C;
            end
        end
        return c;
    endfunction

    // Queue a frame byte and fold it into the batch or live CRC
    function automatic void emit_byte(input logic [7:0] b, input bit to_live);
        t_frame_byte fb;
        fb.data   = b;
        fb.is_crc = 1'b0;
        fb.last   = 1'b0;
        expected_bytes.push_back(fb);
        bytes_predicted++;
        if (to_live) begin
            live_crc = crc8_update(live_crc, b);
        end else begin
            batch_crc = crc8_update(batch_crc, b);
        end
    endfunction

    function automatic void emit_crc(input logic [7:0] c);
        t_frame_byte fb;
        fb.data   = c;
        fb.is_crc = 1'b1;
        fb.last   = 1'b0;
        expected_bytes.push_back(fb);
        bytes_predicted++;
    endfunction

    function automatic void reset_frame_state();
        batch_ver_reg = BATCH_VER_RST;
        live_ver_reg  = LIVE_VER_RST;
        batch_crc     = 8'h00;
        live_crc      = 8'h00;
        samples_due   = 0;
        samples_seen  = 0;
        batch_is_open = 1'b0;
        foreach (speed_words[i]) speed_words[i] = 16'h0000;
    endfunction

    // Work out the frame bytes one accepted item causes; returns their number
    function automatic int predict_frame_bytes(input t_op op, input t_item it);
        int cnt;
        bytes_predicted = 0;
        case (op)
            OP_HDR: begin
                cnt = (it.sample_count > SAMPLE_DEPTH) ? SAMPLE_DEPTH : it.sample_count;
                batch_crc = 8'h00;
                emit_byte(batch_ver_reg, 1'b0);
                emit_byte(it.cycle_number[7:0], 1'b0);
                emit_byte(it.cycle_number[15:8], 1'b0);
                emit_byte(8'(cnt), 1'b0);
                emit_byte(8'h00, 1'b0);
                emit_byte(it.battery_mv[7:0], 1'b0);
                emit_byte(it.battery_mv[15:8], 1'b0);
                emit_byte(it.panel_mv[7:0], 1'b0);
                emit_byte(it.panel_mv[15:8], 1'b0);
                emit_byte(it.signal_quality, 1'b0);
                samples_due  = cnt;
                samples_seen = 0;
                if (cnt == 0) begin
                    emit_crc(batch_crc);
                    batch_is_open = 1'b0;
                end else begin
                    batch_is_open = 1'b1;
                end
            end
            OP_SAMPLE: begin
                // Only samples of an open, unfinished batch count
                if (batch_is_open && samples_seen < samples_due) begin
                    speed_words[samples_seen] = it.speed_word;
                    samples_seen++;
                    emit_byte(it.vane_byte, 1'b0);
                    if (samples_seen == samples_due) begin
                        for (int i = 0; i < samples_seen; i++) begin
                            emit_byte(speed_words[i][7:0], 1'b0);
                            emit_byte(speed_words[i][15:8], 1'b0);
                        end
                        emit_crc(batch_crc);
                        batch_is_open = 1'b0;
                    end
                end
            end
            OP_LIVE: begin
                // Separate CRC, batch progress untouched
                live_crc = 8'h00;
                emit_byte(live_ver_reg, 1'b1);
                emit_byte(it.vane_on, 1'b1);
                emit_byte(it.vane_off, 1'b1);
                emit_byte(it.pulse_rate[7:0], 1'b1);
                emit_byte(it.pulse_rate[15:8], 1'b1);
                emit_byte(it.battery_mv[7:0], 1'b1);
                emit_byte(it.battery_mv[15:8], 1'b1);
                emit_byte(it.panel_mv[7:0], 1'b1);
                emit_byte(it.panel_mv[15:8], 1'b1);
                emit_byte(it.signal_quality, 1'b1);
                emit_crc(live_crc);
            end
            default: begin
            end
        endcase
        if (bytes_predicted > 0) begin
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
        end
        return bytes_predicted;
    endfunction

    // Output checker: each master transfer against the oldest expected byte
    always @(posedge i_clk) begin : check_output
        t_frame_byte exp_b;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_bytes.size() == 0) begin
                error_count++;
                $display("%0t: unexpected byte, expected none, got data %02h tuser %0b tlast %0b",
                         $time, o_m_tdata, o_m_tuser, o_m_tlast);
            end else begin
                exp_b = expected_bytes.pop_front();
                if (o_m_tdata !== exp_b.data) begin
                    error_count++;
                    $display("%0t: out_byte expected %02h, got %02h",
                             $time, exp_b.data, o_m_tdata);
                end
                if (o_m_tuser !== exp_b.is_crc) begin
                    error_count++;
                    $display("%0t: is_crc expected %0b, got %0b",
                             $time, exp_b.is_crc, o_m_tuser);
                end
                if (o_m_tlast !== exp_b.last) begin
                    error_count++;
                    $display("%0t: last expected %0b, got %0b",
                             $time, exp_b.last, o_m_tlast);
                end
            end
        end
    end

    // Receiver: ready runs with random stall bursts, none once steady_flow is set
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_tready <= 1'b1;
            repeat ($urandom_range(0, 23)) @(negedge i_clk);
            if (!steady_flow && $urandom_range(0, 1) == 1) begin
                @(negedge i_clk);
                i_m_tready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge i_clk);
            end
        end
    end

    // Send one item, with an optional gap ahead of it; returns at its transfer edge
    task automatic send_item(input t_op op, input t_item it);
        int n;
        @(negedge i_clk);
        if (!steady_flow && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        it.pad = '0;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= it;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        n = predict_frame_bytes(op, it);
        if (n > 0) begin
            items_with_output++;
        end
    endtask

    // Drop valid, let every expected byte arrive, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic apb_transfer(input bit wr, input logic [APB_AW-1:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Read both version registers back against the shadow copies
    task automatic check_version_regs();
        logic [31:0] rd;
        apb_transfer(1'b0, ADDR_BATCH_VER, 32'h0, rd);
        if (rd !== {24'h0, batch_ver_reg}) begin
            error_count++;
            $display("%0t: batch_version read expected %08h, got %08h",
                     $time, {24'h0, batch_ver_reg}, rd);
        end
        apb_transfer(1'b0, ADDR_LIVE_VER, 32'h0, rd);
        if (rd !== {24'h0, live_ver_reg}) begin
            error_count++;
            $display("%0t: live_version read expected %08h, got %08h",
                     $time, {24'h0, live_ver_reg}, rd);
        end
    endtask

    task automatic set_versions(input logic [7:0] bv, input logic [7:0] lv);
        logic [31:0] rd;
        wait_idle();
        apb_transfer(1'b1, ADDR_BATCH_VER, {24'h0, bv}, rd);
        batch_ver_reg = bv;
        apb_transfer(1'b1, ADDR_LIVE_VER, {24'h0, lv}, rd);
        live_ver_reg = lv;
        check_version_regs();
    endtask

    function automatic t_item rand_fields();
        t_item it;
        it.pad            = '0;
        it.cycle_number   = 16'($urandom);
        it.sample_count   = 5'($urandom);
        it.battery_mv     = 16'($urandom);
        it.panel_mv       = 16'($urandom);
        it.signal_quality = 8'($urandom);
        it.vane_byte      = 8'($urandom);
        it.speed_word     = 16'($urandom);
        it.vane_on        = 8'($urandom);
        it.vane_off       = 8'($urandom);
        it.pulse_rate     = 16'($urandom);
        return it;
    endfunction

    // Mostly short batches, some empty, some longer up to full, a few oversized
    function automatic int pick_sample_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3) return 0;
        if (r < 14) return $urandom_range(1, 4);
        if (r < 18) return $urandom_range(5, SAMPLE_DEPTH);
        return $urandom_range(SAMPLE_DEPTH + 1, 31);
    endfunction

    // Version read-back, live frames at both extremes, an empty batch, an unused op code
    task automatic test_single_frames();
        t_item it;
        check_version_regs();
        it = '0;
        send_item(OP_LIVE, it);
        it = '1;
        send_item(OP_LIVE, it);
        it.sample_count = 0;
        send_item(OP_HDR, it);
        send_item(OP_NONE, rand_fields());
    endtask

    // Live record inside a batch, and a batch abandoned by a new header
    task automatic test_batch_interleave();
        t_item it;
        it = '0;
        it.sample_count = 2;
        send_item(OP_HDR, it);
        it = '1;
        send_item(OP_SAMPLE, it);
        send_item(OP_LIVE, it);
        it = '0;
        send_item(OP_SAMPLE, it);
        it = rand_fields();
        it.sample_count = 3;
        send_item(OP_HDR, it);
        send_item(OP_SAMPLE, rand_fields());
        it = rand_fields();
        it.sample_count = 1;
        send_item(OP_HDR, it);
        send_item(OP_SAMPLE, rand_fields());
    endtask

    // Oversized count saturates; a full store dumps, then a stray sample is dropped
    task automatic test_full_batch();
        t_item it;
        it = '1;
        send_item(OP_HDR, it);
        for (int s = 0; s < SAMPLE_DEPTH; s++) begin
            send_item(OP_SAMPLE, rand_fields());
        end
        send_item(OP_SAMPLE, rand_fields());
    endtask

    // Batches with random content, some abandoned, plus live records, noise and pauses
    task automatic test_random_traffic(input int n_items);
        t_item it;
        int    goal;
        int    pick;
        int    cnt;
        goal = items_with_output + n_items;
        while (items_with_output < goal) begin
            pick = $urandom_range(0, 19);
            it   = rand_fields();
            if (pick < 14) begin
                it.sample_count = 5'(pick_sample_count());
                send_item(OP_HDR, it);
                cnt = (it.sample_count > SAMPLE_DEPTH) ? SAMPLE_DEPTH : it.sample_count;
                for (int s = 0; s < cnt; s++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        send_item(OP_LIVE, rand_fields());
                    end
                    // Occasionally walk away from the batch
                    if ($urandom_range(0, 29) == 0) begin
                        break;
                    end
                    send_item(OP_SAMPLE, rand_fields());
                end
            end else if (pick < 16) begin
                send_item(OP_LIVE, it);
            end else if (pick < 18) begin
                send_item(OP_SAMPLE, it);
            end else if (pick < 19) begin
                send_item(OP_NONE, it);
            end else if (!steady_flow) begin
                wait_idle();
            end
        end
    endtask

    // Final stretch with no gaps and no stalls
    task automatic test_steady_flow();
        set_versions(8'hFF, 8'h00);
        steady_flow = 1'b1;
        test_random_traffic(20);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_s_tvalid        = 1'b0;
        i_s_tdata         = '0;
        i_s_tuser         = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        error_count       = 0;
        items_with_output = 0;
        steady_flow       = 1'b0;
        reset_frame_state();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_frames();
        test_batch_interleave();
        test_full_batch();
        set_versions(8'h00, 8'hFF);
        test_random_traffic(35);
        set_versions(8'($urandom), 8'($urandom));
        test_random_traffic(35);
        test_steady_flow();
        wait_idle();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tfb_pkg.sv
hdl/tfb_ctrl.sv
hdl/tfb_dp.sv
hdl/telemetry_frame_builder_crc8_core.sv
hdl/tfb_chk.sv
bench/telemetry_frame_builder_crc8_core_tb.sv
